/* rtl/vector_distance_accumulator_top_defines.svh */
// Assertion macros shared by the checker of the vector distance accumulator
`ifndef VECTOR_DISTANCE_ACCUMULATOR_TOP_DEFINES_SVH
`define VECTOR_DISTANCE_ACCUMULATOR_TOP_DEFINES_SVH

// Condition in one cycle implies a consequence in the next, quiet during reset
`define VDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vda: next-cycle check failed");

// Condition implies a consequence in the same cycle, quiet during reset
`define VDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vda: same-cycle check failed");

// Next-cycle check that also runs while reset is applied
`define VDA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vda: reset check failed");

`endif

/* rtl/vda_pkg.sv */
// Types and constants of the vector distance accumulator
package vda_pkg;

    localparam int IN_W       = 16;
    localparam int DIFF_W     = IN_W + 1;
    localparam int TERM_W     = 2 * DIFF_W;
    localparam int ACC_W      = 44;
    localparam int DIST_W     = 28;
    localparam int ROOT_STEPS = ACC_W / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // register index of the mode register
    localparam logic REG_NORM_MODE = 1'b0;

    typedef enum logic [1:0] {
        MODE_NONZERO = 2'd0,
        MODE_SUM     = 2'd1,
        MODE_EUCLID  = 2'd2,
        MODE_MAX     = 2'd3
    } t_mode;

    localparam t_mode MODE_RESET = MODE_EUCLID;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_ROOT,
        ST_SEND
    } t_state;

    typedef struct packed {
        logic take;
        logic out_load_fin;
        logic root_init;
        logic root_step;
    } t_cmd;

    typedef struct packed {
        logic fin_done;
        logic root_last;
    } t_stat;

endpackage

/* rtl/vda_ctrl.sv */
// Controller state machine of the vector distance accumulator
module vda_ctrl
    import vda_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_last,
    input  logic  i_ready,
    input  t_mode i_mode,
    input  t_stat i_stat,
    output logic  o_ready,
    output logic  o_valid,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // advance the state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (i_valid && i_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_stat.fin_done) begin
                    n_state = (i_mode == MODE_EUCLID) ? ST_ROOT : ST_SEND;
                end
            end
            ST_ROOT: begin
                if (i_stat.root_last) begin
                    n_state = ST_SEND;
                end
            end
            ST_SEND: begin
                if (i_ready) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // drive handshakes and datapath commands
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_RUN: begin
                o_ready    = 1'b1;
                o_cmd.take = i_valid;
            end
            ST_WAIT: begin
                if (i_stat.fin_done) begin
                    o_cmd.root_init    = (i_mode == MODE_EUCLID);
                    o_cmd.out_load_fin = (i_mode != MODE_EUCLID);
                end
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            ST_SEND: begin
                o_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/vda_dpath.sv */
// Datapath: difference pipeline, accumulator, square root unit, result register
module vda_dpath
    import vda_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  t_mode                    i_mode,
    input  logic signed [IN_W-1:0]   i_elem_a,
    input  logic signed [IN_W-1:0]   i_elem_b,
    input  logic                     i_last,
    output t_stat                    o_stat,
    output logic        [DIST_W-1:0] o_distance,
    output logic                     o_saturated
);

    localparam int SH = IN_W - ELEM_WIDTH;

    // stage 1: absolute difference
    logic signed [IN_W-1:0]   w_a;
    logic signed [IN_W-1:0]   w_b;
    logic signed [DIFF_W-1:0] w_d;
    logic        [DIFF_W-1:0] w_abs;
    logic                     r_s1_v;
    logic                     r_s1_last;
    logic        [DIFF_W-1:0] r_diff;

    // stage 2: term to fold
    logic                     r_s2_v;
    logic                     r_s2_last;
    logic        [TERM_W-1:0] r_term;
    logic        [TERM_W-1:0] n_term;

    // accumulator
    logic        [ACC_W-1:0]  r_acc;
    logic        [ACC_W-1:0]  n_acc;
    logic                     r_clip;
    logic                     n_clip;
    logic        [ACC_W:0]    w_sum;
    logic        [ACC_W-1:0]  w_term_x;
    logic        [ACC_W-1:0]  r_fin;
    logic                     r_fin_clip;
    logic                     r_fin_done;

    // square root unit
    logic        [ACC_W-1:0]  r_rem;
    logic        [ACC_W-1:0]  r_res;
    logic        [CNT_W-1:0]  r_cnt;
    logic        [ACC_W-1:0]  w_bit;
    logic        [ACC_W-1:0]  w_trial;
    logic        [ACC_W:0]    w_sub;
    logic        [ACC_W-1:0]  n_rem;
    logic        [ACC_W-1:0]  n_res;

    // result register
    logic        [DIST_W-1:0] r_dist;
    logic                     r_sat;

    // take the low element bits as two's complement at the element width
    assign w_a   = $signed(i_elem_a <<< SH) >>> SH;
    assign w_b   = $signed(i_elem_b <<< SH) >>> SH;
    assign w_d   = DIFF_W'(w_a) - DIFF_W'(w_b);
    assign w_abs = w_d[DIFF_W-1] ? DIFF_W'(-w_d) : DIFF_W'(w_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_cmd.take;
        end
        if (i_cmd.take) begin
            r_diff    <= w_abs;
            r_s1_last <= i_last;
        end
    end

    // form the term under the current mode
    always_comb begin
        case (i_mode)
            MODE_NONZERO: n_term = TERM_W'(r_diff != '0);
            MODE_EUCLID:  n_term = r_diff * r_diff;
            default:      n_term = TERM_W'(r_diff);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        if (r_s1_v) begin
            r_term    <= n_term;
            r_s2_last <= r_s1_last;
        end
    end

    // fold the term: saturating add, or running maximum
    assign w_term_x = ACC_W'(r_term);
    assign w_sum    = {1'b0, r_acc} + {1'b0, w_term_x};

    always_comb begin
        n_acc  = r_acc;
        n_clip = r_clip;
        if (i_mode == MODE_MAX) begin
            if (w_term_x > r_acc) begin
                n_acc = w_term_x;
            end
        end else if (w_sum[ACC_W]) begin
            n_acc  = ACC_MAX;
            n_clip = 1'b1;
        end else begin
            n_acc = w_sum[ACC_W-1:0];
        end
    end

    // update the accumulator, and on the final pair hand it over and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_clip     <= 1'b0;
            r_fin_done <= 1'b0;
        end else begin
            r_fin_done <= r_s2_v && r_s2_last;
            if (r_s2_v) begin
                if (r_s2_last) begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                end else begin
                    r_acc  <= n_acc;
                    r_clip <= n_clip;
                end
            end
        end
        if (r_s2_v && r_s2_last) begin
            r_fin      <= n_acc;
            r_fin_clip <= n_clip;
        end
    end

    // one square root digit per cycle
    assign w_bit   = ACC_W'(1) << {r_cnt, 1'b0};
    assign w_trial = r_res + w_bit;
    assign w_sub   = {1'b0, r_rem} - {1'b0, w_trial};

    always_comb begin
        if (!w_sub[ACC_W]) begin
            n_rem = w_sub[ACC_W-1:0];
            n_res = (r_res >> 1) + w_bit;
        end else begin
            n_rem = r_rem;
            n_res = r_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_rem <= r_fin;
            r_res <= '0;
            r_cnt <= CNT_W'(ROOT_STEPS - 1);
        end else if (i_cmd.root_step) begin
            r_rem <= n_rem;
            r_res <= n_res;
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // load the result, clipping the direct value at the distance range
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load_fin) begin
            if (r_fin > ACC_W'(DIST_MAX)) begin
                r_dist <= DIST_MAX;
                r_sat  <= 1'b1;
            end else begin
                r_dist <= r_fin[DIST_W-1:0];
                r_sat  <= r_fin_clip;
            end
        end else if (i_cmd.root_step && (r_cnt == '0)) begin
            r_dist <= n_res[DIST_W-1:0];
            r_sat  <= r_fin_clip;
        end
    end

    assign o_stat.fin_done  = r_fin_done;
    assign o_stat.root_last = (r_cnt == '0);
    assign o_distance       = r_dist;
    assign o_saturated      = r_sat;

endmodule

/* rtl/vector_distance_accumulator_top.sv */
// Top level of the vector distance accumulator with its register port
//
// Element pairs are taken at one per cycle while a vector streams in. The
// pair marked last closes the vector: input stalls from that transfer until
// the result is taken. The pair passes a three-deep pipeline (difference,
// term, accumulator) and then the result register, which shows a count,
// sum or maximum result directly; in euclidean mode the iterative square
// root unit comes in between and finds the 22 root digits one at a time.
// Nothing needs clearing after reset. The mode register lies at byte
// address 0 and is read back there; change it only while no vector is in
// progress.
module vector_distance_accumulator_top
    import vda_pkg::*;
#(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [IN_W-1:0]   i_elem_a,
    input  logic signed [IN_W-1:0]   i_elem_b,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic        [DIST_W-1:0] o_distance,
    output logic                     o_saturated,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic        [ADDR_W-1:0] paddr,
    input  logic        [DATA_W-1:0] pwdata,
    output logic        [DATA_W-1:0] prdata,
    output logic                     pready
);

    t_mode r_mode;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_wr;
    logic  w_idx;

    // decode register transfers
    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (w_wr && (w_idx == REG_NORM_MODE)) begin
            r_mode <= t_mode'(pwdata[1:0]);
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_NORM_MODE: prdata = DATA_W'(r_mode);
            default:       prdata = '0;
        endcase
    end

    vda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .i_ready (i_ready),
        .i_mode  (r_mode),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    vda_dpath #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_mode      (r_mode),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .i_last      (i_last),
        .o_stat      (w_stat),
        .o_distance  (o_distance),
        .o_saturated (o_saturated)
    );

endmodule

/* rtl/vda_checker.sv */
// Port-level checks of the vector distance accumulator, bound to the top level
`include "vector_distance_accumulator_top_defines.svh"

module vda_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic i_last,
    input logic o_valid,
    input logic i_ready
);

    // a pending result is held until taken
    `VDA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // no pair is taken while a result waits
    `VDA_ASSERT_SAME(a_no_take_pending, i_clk, i_rst_n, o_valid, !o_ready)
    // the closing pair stalls the input
    `VDA_ASSERT_NEXT(a_last_stalls, i_clk, i_rst_n, i_valid && o_ready && i_last, !o_ready)
    // reset drops any result
    `VDA_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_valid)

endmodule

bind vector_distance_accumulator_top vda_checker u_vda_checker (.*);

/* tb/vector_distance_accumulator_top_tb.sv */
// Self-checking testbench of the vector distance accumulator: directed table and random vectors
module vector_distance_accumulator_top_tb;
    import vda_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 150;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 500;
    localparam int LIMIT_TIME    = 8 * 600000;

    localparam logic [ADDR_W-1:0] ADDR_NORM_MODE = ADDR_W'(4 * REG_NORM_MODE);
    localparam logic [ADDR_W-1:0] ADDR_UNUSED    = ADDR_W'(4);

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              sat;
    } t_dist_res;

    typedef struct packed {
        t_mode                  mode;
        logic signed [IN_W-1:0] a;
        logic signed [IN_W-1:0] b;
        logic                   last;
        logic                   typed;
        t_dist_res              res;
    } t_stim_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [IN_W-1:0]   i_elem_a;
    logic signed [IN_W-1:0]   i_elem_b;
    logic                     i_last;
    logic                     o_valid;
    logic                     i_ready;
    logic        [DIST_W-1:0] o_distance;
    logic                     o_saturated;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic        [ADDR_W-1:0] paddr;
    logic        [DATA_W-1:0] pwdata;
    logic        [DATA_W-1:0] prdata;
    logic                     pready;

    // predicted block state
    t_mode       cur_mode;
    logic [63:0] dist_acc;
    bit          dist_clip;

    t_dist_res   pending_dist_q[$];
    t_stim_row   dir_rows[$];
    t_dist_res   want;
    int          errors;
    int          results_taken;
    int unsigned burst_left;
    bit          held;
    int unsigned ready_style;
    int unsigned ready_span;
    int unsigned ready_phase;

    vector_distance_accumulator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_elem_a    (i_elem_a),
        .i_elem_b    (i_elem_b),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_distance  (o_distance),
        .o_saturated (o_saturated),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // free-running clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // end the run if it hangs
    initial begin
        #LIMIT_TIME;
        $display("Simulation FAILED");
        $finish;
    end

    // floor of the integer square root, one bit per step from the top
    function automatic logic [DIST_W-1:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        r = 64'd0;
        for (int k = 21; k >= 0; k--) begin
            trial = r | (64'd1 << k);
            if (trial * trial <= v)
                r = trial;
        end
        return r[DIST_W-1:0];
    endfunction

    // add into the accumulator, clipping at its top
    task automatic acc_add_clip(input logic [63:0] x);
        logic [63:0] s;
        s = dist_acc + x;
        if (s > 64'(ACC_MAX)) begin
            s = 64'(ACC_MAX);
            dist_clip = 1'b1;
        end
        dist_acc = s;
    endtask

    // fold one pair into the distance and close the vector on last
    task automatic fold_pair(input logic signed [IN_W-1:0] a, input logic signed [IN_W-1:0] b,
                             input logic last, output bit got, output t_dist_res res);
        int          d;
        logic [63:0] mag;
        logic [63:0] val;
        bit          sat;
        d = int'(a) - int'(b);
        mag = 64'((d < 0) ? -d : d);
        case (cur_mode)
            MODE_NONZERO: if (mag != 64'd0) acc_add_clip(64'd1);
            MODE_SUM:     acc_add_clip(mag);
            MODE_EUCLID:  acc_add_clip(mag * mag);
            default:      if (mag > dist_acc) dist_acc = mag;
        endcase
        res = '0;
        got = 1'b0;
        if (last) begin
            val = (cur_mode == MODE_EUCLID) ? 64'(floor_root(dist_acc)) : dist_acc;
            sat = dist_clip;
            if (val > 64'(DIST_MAX)) begin
                val = 64'(DIST_MAX);
                sat = 1'b1;
            end
            res.distance = val[DIST_W-1:0];
            res.sat = sat;
            got = 1'b1;
            dist_acc = 64'd0;
            dist_clip = 1'b0;
        end
    endtask

    // offer one pair in bursts with random gaps, and log its expectation on transfer
    task automatic send_pair(input logic signed [IN_W-1:0] a, input logic signed [IN_W-1:0] b,
                             input logic last, input bit typed, input t_dist_res typed_res);
        t_dist_res pred;
        bit        got;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_elem_a <= a;
        i_elem_b <= b;
        i_last   <= last;
        do @(posedge i_clk); while (!o_ready);
        fold_pair(a, b, last, got, pred);
        if (got)
            pending_dist_q.push_back(typed ? typed_res : pred);
    endtask

    // write a register once the block is quiet, then read the mode back
    task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_dist_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_NORM_MODE)
            cur_mode = t_mode'(data[1:0]);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_NORM_MODE;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[1:0] !== cur_mode) begin
            $display("%0t: mode readback mismatch: expected %0d, actual %0d",
                     $time, cur_mode, prdata[1:0]);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_stim_row stim_row(input t_mode m, input logic signed [IN_W-1:0] a,
                                           input logic signed [IN_W-1:0] b, input logic l,
                                           input logic typed, input logic [DIST_W-1:0] d,
                                           input logic s);
        t_stim_row r;
        r.mode = m;
        r.a = a;
        r.b = b;
        r.last = l;
        r.typed = typed;
        r.res.distance = d;
        r.res.sat = s;
        return r;
    endfunction

    // element value weighted towards the extremes and small numbers
    function automatic logic signed [IN_W-1:0] pick_elem();
        int unsigned r;
        r = $urandom();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return IN_W'(int'($urandom_range(0, 15)) - 8);
            default: return r[IN_W-1:0];
        endcase
    endfunction

    // check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_taken++;
            if (pending_dist_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual distance %0d sat %0b",
                         $time, o_distance, o_saturated);
                errors++;
            end else begin
                want = pending_dist_q.pop_front();
                if (o_distance !== want.distance) begin
                    $display("%0t: distance mismatch: expected %0d, actual %0d",
                             $time, want.distance, o_distance);
                    errors++;
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated mismatch: expected %0b, actual %0b",
                             $time, want.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    // receiver: stall on changing patterns, with one long hold-off under load
    initial begin
        i_ready = 1'b0;
        held = 1'b0;
        ready_phase = 0;
        forever begin
            ready_style = $urandom_range(0, 3);
            ready_span = $urandom_range(20, 200);
            repeat (ready_span) begin
                @(negedge i_clk);
                if (!held && results_taken >= HOLD_AT && i_valid) begin
                    held = 1'b1;
                    i_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge i_clk);
                end
                ready_phase++;
                case (ready_style)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= (ready_phase % 4 == 0);
                    default: i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // main sequence
    initial begin
        logic [DATA_W-1:0] rnd;
        t_mode             m;
        int unsigned       sent;
        int unsigned       len;
        logic signed [IN_W-1:0] ea;
        logic signed [IN_W-1:0] eb;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_elem_a = '0;
        i_elem_b = '0;
        i_last   = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        errors = 0;
        results_taken = 0;
        burst_left = 0;
        cur_mode = MODE_RESET;
        dist_acc = 64'd0;
        dist_clip = 1'b0;

        // directed table: the reset mode first, then each mode at its extremes
        dir_rows.push_back(stim_row(MODE_EUCLID, 3, 0, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_EUCLID, 0, 4, 1'b1, 1'b1, 5, 1'b0));
        dir_rows.push_back(stim_row(MODE_EUCLID, 32767, -32768, 1'b1, 1'b1, 65535, 1'b0));
        dir_rows.push_back(stim_row(MODE_EUCLID, -32768, -32768, 1'b1, 1'b1, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_EUCLID, 300, -200, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_EUCLID, 17, 9, 1'b1, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_SUM, -32768, 32767, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_SUM, 32767, -32768, 1'b1, 1'b1, 131070, 1'b0));
        dir_rows.push_back(stim_row(MODE_SUM, 5, 5, 1'b1, 1'b1, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_NONZERO, 1, 0, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_NONZERO, 7, 7, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_NONZERO, -1, 1, 1'b1, 1'b1, 2, 1'b0));
        dir_rows.push_back(stim_row(MODE_NONZERO, 0, 0, 1'b1, 1'b1, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_MAX, 100, -100, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_MAX, -32768, 32767, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(stim_row(MODE_MAX, 0, 1, 1'b1, 1'b1, 65535, 1'b0));
        dir_rows.push_back(stim_row(MODE_MAX, -5, -9, 1'b1, 1'b1, 4, 1'b0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != cur_mode)
                write_reg(ADDR_NORM_MODE, DATA_W'(dir_rows[i].mode));
            send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].res);
        end

        // a write to an unused index must leave the mode alone
        rnd = $urandom();
        write_reg(ADDR_UNUSED, rnd);

        // random vectors, mostly short, each phase under one mode
        for (int p = 0; p < RAND_PHASES; p++) begin
            m = (p < 4) ? t_mode'(p) : t_mode'($urandom_range(0, 3));
            rnd = $urandom();
            write_reg(ADDR_NORM_MODE, {rnd[DATA_W-1:2], m});
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                  : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    ea = pick_elem();
                    eb = ($urandom_range(0, 5) == 0) ? ea : pick_elem();
                    send_pair(ea, eb, k == len - 1, 1'b0, '0);
                    sent++;
                end
            end
        end

        // drop valid and let the last results drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_dist_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* vector_distance_accumulator_top.f */
+incdir+rtl
rtl/vda_pkg.sv
rtl/vda_ctrl.sv
rtl/vda_dpath.sv
rtl/vector_distance_accumulator_top.sv
rtl/vda_checker.sv
tb/vector_distance_accumulator_top_tb.sv
